FILE: design/olpd_pkg.sv
// Shared types, codes and sizes for the ordered list block.
`timescale 1ns / 1ps
`default_nettype none
package olpd_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LEN_W    = $clog2(CAPACITY + 1);
   localparam int ACTION_W = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 8;
   localparam int STATUS_W = 2;
   localparam int LENGTH_W = 5;
   localparam int CMP_W    = (LEN_W > POS_W) ? LEN_W : POS_W;

   localparam int QDEPTH   = 2;
   localparam int QPTR_W   = $clog2(QDEPTH);
   localparam int QCNT_W   = $clog2(QDEPTH + 1);

   localparam logic [ACTION_W-1:0] ACT_APPEND    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_READ      = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_RM_FIRST  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_RM_LAST   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_RM_POS    = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_READ  = 2'd3;

   typedef enum logic [2:0] {
      OP_APPEND,
      OP_READ,
      OP_RM_LAST,
      OP_RM_POS,
      OP_NOP
   } op_type;

   // One classified request as it travels from the front to the back.
   typedef struct packed {
      op_type                     op;
      logic signed [VALUE_W-1:0]  value;
      logic [POS_W-1:0]           idx;
   } cmd_type;

endpackage
`default_nettype wire

FILE: design/olpd_front.sv
// Front end: accepts requests and turns them into classified commands.
`timescale 1ns / 1ps
`default_nettype none
module olpd_front import olpd_pkg::*; (
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [ACTION_W-1:0]       req_action,
   input  wire logic signed [VALUE_W-1:0] req_value,
   input  wire logic [POS_W-1:0]          req_position,
   output logic                           push_valid,
   input  wire logic                      push_ready,
   output cmd_type                        push_cmd
);

   always_comb begin
      push_cmd.value = req_value;
      push_cmd.idx   = '0;
      case (req_action)
         ACT_APPEND:   push_cmd.op = OP_APPEND;
         ACT_READ:     push_cmd.op = OP_READ;
         ACT_RM_FIRST: push_cmd.op = OP_RM_POS;
         ACT_RM_LAST:  push_cmd.op = OP_RM_LAST;
         ACT_RM_POS: begin
            push_cmd.op = OP_RM_POS;
            // convert to a 0-based index; positions 0 and 1 both mean the head
            if (req_position > POS_W'(1)) begin
               push_cmd.idx = req_position - POS_W'(1);
            end
         end
         default:      push_cmd.op = OP_NOP;
      endcase
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule
`default_nettype wire

FILE: design/olpd_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module olpd_queue import olpd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire cmd_type in_cmd,
   output logic         out_valid,
   input  wire logic    out_ready,
   output cmd_type      out_cmd
);

   cmd_type             entry_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic                push;
   logic                pop;

   assign in_ready  = (count_ff != QCNT_W'(QDEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

endmodule
`default_nettype wire

FILE: design/olpd_back.sv
// Back end: holds the list, runs removals and read-out, drives the results.
`timescale 1ns / 1ps
`default_nettype none
module olpd_back import olpd_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                cmd_valid,
   output logic                     cmd_ready,
   input  wire cmd_type             cmd,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_element,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [LENGTH_W-1:0]      rsp_length,
   output logic                     rsp_last
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SHIFT,
      S_FINISH,
      S_READ
   } state_type;

   state_type                 state_ff;
   logic [LEN_W-1:0]          fill_ff;
   logic [IDX_W-1:0]          ptr_ff;
   logic                      rsp_valid_ff;
   logic signed [VALUE_W-1:0] rsp_element_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic [LENGTH_W-1:0]       rsp_length_ff;
   logic                      rsp_last_ff;

   logic [VALUE_W-1:0]        slots_ff [CAPACITY];

   logic                      out_free;
   logic [LEN_W-1:0]          fill_m1;
   logic [IDX_W-1:0]          ptr_next;
   logic [IDX_W-1:0]          rd_addr;
   logic [VALUE_W-1:0]        rd_data;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   logic [VALUE_W-1:0]        wr_data;
   logic                      shift_more;
   logic                      read_final;
   logic [IDX_W-1:0]          rm_idx;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = (state_ff == S_IDLE) && out_free;
   assign fill_m1   = fill_ff - LEN_W'(1);
   assign ptr_next  = ptr_ff + IDX_W'(1);

   assign shift_more = (LEN_W'(ptr_ff) + LEN_W'(1)) < fill_ff;
   assign read_final = (LEN_W'(ptr_ff) + LEN_W'(1)) == fill_ff;
   // clamp a position past the tail to the last element
   assign rm_idx = (CMP_W'(cmd.idx) >= CMP_W'(fill_m1)) ? fill_m1[IDX_W-1:0]
                                                        : cmd.idx[IDX_W-1:0];

   // single read port: the shift pulls the next entry, read-out the current one
   assign rd_addr = (state_ff == S_SHIFT) ? ptr_next : ptr_ff;
   assign rd_data = slots_ff[rd_addr];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ptr_ff;
      wr_data = rd_data;
      if (state_ff == S_SHIFT) begin
         wr_en = shift_more;
      end else if (cmd_valid && cmd_ready && cmd.op == OP_APPEND
                   && fill_ff < LEN_W'(CAPACITY)) begin
         wr_en   = 1'b1;
         wr_addr = fill_ff[IDX_W-1:0];
         wr_data = cmd.value;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid && cmd_ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_element_ff <= '0;
                  rsp_status_ff  <= STATUS_DONE;
                  rsp_length_ff  <= LENGTH_W'(fill_ff);
                  rsp_last_ff    <= 1'b1;
                  if (cmd.op == OP_APPEND) begin
                     if (fill_ff >= LEN_W'(CAPACITY)) begin
                        rsp_status_ff <= STATUS_FULL;
                     end else begin
                        fill_ff       <= fill_ff + LEN_W'(1);
                        rsp_length_ff <= LENGTH_W'(fill_ff + LEN_W'(1));
                     end
                  end else if (cmd.op == OP_NOP) begin
                     rsp_status_ff <= STATUS_DONE;
                  end else if (fill_ff == '0) begin
                     rsp_status_ff <= STATUS_EMPTY;
                  end else begin
                     case (cmd.op)
                        OP_READ: begin
                           rsp_valid_ff <= 1'b0;
                           ptr_ff       <= '0;
                           state_ff     <= S_READ;
                        end
                        OP_RM_LAST: begin
                           fill_ff       <= fill_m1;
                           rsp_length_ff <= LENGTH_W'(fill_m1);
                        end
                        OP_RM_POS: begin
                           rsp_valid_ff <= 1'b0;
                           ptr_ff       <= rm_idx;
                           state_ff     <= S_SHIFT;
                        end
                        default: begin
                           rsp_status_ff <= STATUS_DONE;
                        end
                     endcase
                  end
               end
            end
            S_SHIFT: begin
               // advance one entry per cycle toward the tail
               if (shift_more) begin
                  ptr_ff <= ptr_next;
               end else begin
                  fill_ff  <= fill_m1;
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_element_ff <= '0;
                  rsp_status_ff  <= STATUS_DONE;
                  rsp_length_ff  <= LENGTH_W'(fill_ff);
                  rsp_last_ff    <= 1'b1;
                  state_ff       <= S_IDLE;
               end
            end
            S_READ: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_element_ff <= rd_data;
                  rsp_status_ff  <= STATUS_READ;
                  rsp_length_ff  <= LENGTH_W'(fill_ff);
                  rsp_last_ff    <= read_final;
                  if (read_final) begin
                     state_ff <= S_IDLE;
                  end else begin
                     ptr_ff <= ptr_next;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_length  = rsp_length_ff;
   assign rsp_last    = rsp_last_ff;

endmodule
`default_nettype wire

FILE: design/ordered_list_with_positional_delete.sv
// Top level of the ordered list with positional delete.
`timescale 1ns / 1ps
`default_nettype none
// Ordered list of up to CAPACITY (16) signed 32-bit values. Each request
// transfer carries an action: append, read out all, remove first, remove last
// or remove at a 1-based position (clamped to the list). Requests enter a
// two-entry command queue, so the request side can still take up to two
// requests while a result waits on the response side. The back end executes
// one command at a time: append, remove last, unused codes and any action on
// an empty list are handled directly from idle; a positional removal first
// runs the shift that moves one entry per cycle through the single storage
// port; read-out gives one response transfer per stored value, with last
// marking the final one. Every other action gives one response.
module ordered_list_with_positional_delete import olpd_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [ACTION_W-1:0]       req_action,
   input  wire logic signed [VALUE_W-1:0] req_value,
   input  wire logic [POS_W-1:0]          req_position,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [VALUE_W-1:0]      rsp_element,
   output logic [STATUS_W-1:0]            rsp_status,
   output logic [LENGTH_W-1:0]            rsp_length,
   output logic                           rsp_last
);

   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;
   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   olpd_front u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_action   (req_action),
      .req_value    (req_value),
      .req_position (req_position),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_cmd     (push_cmd)
   );

   olpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_cmd    (push_cmd),
      .out_valid (cmd_valid),
      .out_ready (cmd_ready),
      .out_cmd   (cmd)
   );

   olpd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_element (rsp_element),
      .rsp_status  (rsp_status),
      .rsp_length  (rsp_length),
      .rsp_last    (rsp_last)
   );

endmodule
`default_nettype wire
